@@ rtl/lpd5_pkg.sv @@
// ============================================================================
// lpd5_pkg
// Shared constants and types for the 5x5 local peak detector.
// ============================================================================
package lpd5_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_W          = 12;
    localparam int X_W            = 10;
    localparam int Y_W            = 12;
    localparam int IN_W           = 32;
    localparam int OUT_TDATA_W    = 24;
    localparam int WIN            = 5;
    localparam int LINES          = 4;
    localparam int MIN_MARGIN     = 2;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [31:0] THR_RESET    = 32'd0;
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [12:0] HEIGHT_RESET = 13'd1024;
    localparam logic [8:0]  MARGIN_RESET = 9'd30;

    typedef enum logic [1:0] {
        CFG_THRESHOLD_LOW = 2'd0,
        CFG_FRAME_WIDTH   = 2'd1,
        CFG_FRAME_HEIGHT  = 2'd2,
        CFG_BORDER_MARGIN = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic           valid;
        logic           emit;
        logic [X_W-1:0] center_x;
        logic [Y_W-1:0] center_y;
    } t_ctl;

    typedef struct packed {
        logic           is_peak;
        logic [Y_W-1:0] center_y;
        logic [X_W-1:0] center_x;
    } t_result;

endpackage

@@ rtl/lpd5_line_mem.sv @@
// ============================================================================
// lpd5_line_mem
// Line store: one word per column holding the four previous rows, with a
// registered read and forwarding of a same-column write at the read edge.
// ============================================================================
module lpd5_line_mem #(
    parameter int MAX_WIDTH  = lpd5_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = lpd5_pkg::PIXEL_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 i_rd_addr,
    input  logic                                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 i_wr_addr,
    input  logic [lpd5_pkg::LINES*PIXEL_BITS-1:0]        i_wr_data,
    output logic [lpd5_pkg::LINES*PIXEL_BITS-1:0]        o_rd_data
);

    localparam int WORD_W = lpd5_pkg::LINES * PIXEL_BITS;

    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_fwd_data;
    logic              r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

@@ rtl/lpd5_window.sv @@
// ============================================================================
// lpd5_window
// 5x5 window of samples shifted one column per pixel, followed by the
// strict local-maximum and threshold test on the window centre.
// ============================================================================
module lpd5_window #(
    parameter int PIXEL_BITS = lpd5_pkg::PIXEL_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lpd5_pkg::t_ctl                          i_ctl,
    input  logic [lpd5_pkg::WIN*PIXEL_BITS-1:0]     i_column,
    input  logic signed [PIXEL_BITS-1:0]            i_threshold,
    output logic                                    o_valid,
    output logic                                    o_push,
    output lpd5_pkg::t_result                       o_result
);

    localparam int WIN = lpd5_pkg::WIN;
    localparam int MID = WIN / 2;

    logic signed [PIXEL_BITS-1:0] r_win [WIN][WIN];
    lpd5_pkg::t_ctl               r_ctl;
    logic                         lower_all;
    logic signed [PIXEL_BITS-1:0] centre;

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                r_win[r][WIN-1] <= i_column[r*PIXEL_BITS +: PIXEL_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.emit     <= i_ctl.emit;
        r_ctl.center_x <= i_ctl.center_x;
        r_ctl.center_y <= i_ctl.center_y;
    end

    assign centre = r_win[MID][MID];

    always_comb begin
        lower_all = 1'b1;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
                if ((r != MID || c != MID) && r_win[r][c] >= centre) begin
                    lower_all = 1'b0;
                end
            end
        end
    end

    assign o_valid           = r_ctl.valid;
    assign o_push            = r_ctl.valid && r_ctl.emit;
    assign o_result.is_peak  = lower_all && (centre > i_threshold);
    assign o_result.center_x = r_ctl.center_x;
    assign o_result.center_y = r_ctl.center_y;

endmodule

@@ rtl/lpd5_out_fifo.sv @@
// ============================================================================
// lpd5_out_fifo
// Small result queue that decouples the fixed-latency pipeline from the
// output handshake.
// ============================================================================
module lpd5_out_fifo #(
    parameter int DATA_W = lpd5_pkg::OUT_TDATA_W,
    parameter int DEPTH  = lpd5_pkg::FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [DATA_W-1:0]          i_data,
    input  logic                       i_pop_ready,
    output logic                       o_valid,
    output logic [DATA_W-1:0]          o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              pop;

    assign pop = i_pop_ready && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/local_peak_detect_5x5_unit.sv @@
// ============================================================================
// local_peak_detect_5x5_unit
// Streaming 5x5 local-maximum detector over a raster-order image.
// ============================================================================
// The unit accepts one pixel per clock while s_axis_tready is high and keeps
// the four previous rows in a single line memory read and written back once
// per pixel; results pass through the memory stage, the window stage and a
// four-entry result queue that absorbs output stalls, so input ready drops
// only when the queue together with the two pipeline stages would overflow.
module local_peak_detect_5x5_unit #(
    parameter int MAX_WIDTH  = lpd5_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = lpd5_pkg::PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input pixels.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_value
    input  logic        s_axis_tuser,   // [0] start_of_frame
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [9:0] center_x, [21:10] center_y,
                                        // [22] is_peak, [23] zero
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = lpd5_pkg::ROW_W;
    localparam int SUM_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
    localparam int WORD_W = lpd5_pkg::LINES * PIXEL_BITS;
    localparam int CNT_W  = $clog2(lpd5_pkg::FIFO_DEPTH + 1);

    logic signed [31:0] r_threshold;
    logic [10:0]        r_frame_width;
    logic [12:0]        r_frame_height;
    logic [8:0]         r_border_margin;

    logic [COL_W-1:0]   r_col_pos;
    logic [ROW_W-1:0]   r_row_pos;

    logic               accept;
    logic [SUM_W-1:0]   w_eff, h_eff, m_eff;
    logic [SUM_W-1:0]   col, row, cx, cy, n_col, n_row;
    logic               emit;

    lpd5_pkg::t_ctl               ctl_s0;
    lpd5_pkg::t_ctl               r_s1_ctl;
    logic [COL_W-1:0]             r_s1_col;
    logic [1:0]                   r_s1_slot;
    logic signed [PIXEL_BITS-1:0] r_s1_px;
    logic [WORD_W-1:0]            rd_word;
    logic [WORD_W-1:0]            wr_word;
    logic [lpd5_pkg::WIN*PIXEL_BITS-1:0] column;
    logic [1:0]                   slot;

    logic                         s2_valid;
    logic                         push;
    lpd5_pkg::t_result            result;
    logic [CNT_W-1:0]             fifo_count;
    logic [CNT_W+1:0]             occupancy;
    logic signed [PIXEL_BITS-1:0] threshold_px;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= lpd5_pkg::THR_RESET;
            r_frame_width   <= lpd5_pkg::WIDTH_RESET;
            r_frame_height  <= lpd5_pkg::HEIGHT_RESET;
            r_border_margin <= lpd5_pkg::MARGIN_RESET;
        end else if (i_cfg_valid) begin
            case (lpd5_pkg::t_cfg_index'(i_cfg_index))
                lpd5_pkg::CFG_THRESHOLD_LOW: begin
                    r_threshold <= i_cfg_data;
                end
                lpd5_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[10:0];
                end
                lpd5_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[12:0];
                end
                lpd5_pkg::CFG_BORDER_MARGIN: begin
                    r_border_margin <= i_cfg_data[8:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_eff = SUM_W'(r_frame_width);
        if (w_eff > SUM_W'(MAX_WIDTH)) begin
            w_eff = SUM_W'(MAX_WIDTH);
        end else if (w_eff == '0) begin
            w_eff = SUM_W'(1);
        end
        h_eff = SUM_W'(r_frame_height);
        if (h_eff > SUM_W'(lpd5_pkg::MAX_HEIGHT)) begin
            h_eff = SUM_W'(lpd5_pkg::MAX_HEIGHT);
        end else if (h_eff == '0) begin
            h_eff = SUM_W'(1);
        end
        m_eff = SUM_W'(r_border_margin);
        if (m_eff < SUM_W'(lpd5_pkg::MIN_MARGIN)) begin
            m_eff = SUM_W'(lpd5_pkg::MIN_MARGIN);
        end
    end

    always_comb begin
        if (s_axis_tuser) begin
            col = '0;
            row = '0;
        end else begin
            col = SUM_W'(r_col_pos);
            row = SUM_W'(r_row_pos);
            if (col >= w_eff) begin
                col = '0;
                row = row + SUM_W'(1);
            end
            if (row >= h_eff) begin
                row = '0;
            end
        end
        n_col = col + SUM_W'(1);
        n_row = row;
        if (n_col >= w_eff) begin
            n_col = '0;
            n_row = row + SUM_W'(1);
            if (n_row >= h_eff) begin
                n_row = '0;
            end
        end
        cx   = col - SUM_W'(2);
        cy   = row - SUM_W'(2);
        emit = (col >= SUM_W'(4)) && (row >= SUM_W'(4))
            && (cx >= m_eff) && (cx + m_eff < w_eff)
            && (cy >= m_eff) && (cy + m_eff < h_eff);
    end

    assign occupancy     = (CNT_W+2)'(fifo_count) + (CNT_W+2)'(r_s1_ctl.valid)
                         + (CNT_W+2)'(s2_valid);
    assign s_axis_tready = occupancy < (CNT_W+2)'(lpd5_pkg::FIFO_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (accept) begin
            r_col_pos <= n_col[COL_W-1:0];
            r_row_pos <= n_row[ROW_W-1:0];
        end
    end

    assign ctl_s0.valid    = accept;
    assign ctl_s0.emit     = emit;
    assign ctl_s0.center_x = cx[lpd5_pkg::X_W-1:0];
    assign ctl_s0.center_y = cy[lpd5_pkg::Y_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else begin
            r_s1_ctl.valid <= ctl_s0.valid;
        end
        r_s1_ctl.emit     <= ctl_s0.emit;
        r_s1_ctl.center_x <= ctl_s0.center_x;
        r_s1_ctl.center_y <= ctl_s0.center_y;
        if (accept) begin
            r_s1_col  <= col[COL_W-1:0];
            r_s1_slot <= row[1:0];
            r_s1_px   <= PIXEL_BITS'($signed(s_axis_tdata));
        end
    end

    lpd5_line_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col[COL_W-1:0]),
        .i_wr_en   (r_s1_ctl.valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word)
    );

    always_comb begin
        wr_word = rd_word;
        wr_word[r_s1_slot*PIXEL_BITS +: PIXEL_BITS] = r_s1_px;
        for (int r = 0; r < lpd5_pkg::LINES; r++) begin
            slot = r_s1_slot + 2'(r);
            column[r*PIXEL_BITS +: PIXEL_BITS] = rd_word[slot*PIXEL_BITS +: PIXEL_BITS];
        end
        column[lpd5_pkg::LINES*PIXEL_BITS +: PIXEL_BITS] = r_s1_px;
    end

    assign threshold_px = PIXEL_BITS'(r_threshold);

    lpd5_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1_ctl),
        .i_column    (column),
        .i_threshold (threshold_px),
        .o_valid     (s2_valid),
        .o_push      (push),
        .o_result    (result)
    );

    lpd5_out_fifo #(
        .DATA_W (lpd5_pkg::OUT_TDATA_W),
        .DEPTH  (lpd5_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      ({1'b0, result}),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (m_axis_tdata),
        .o_count     (fifo_count)
    );

    a_accept_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_ctl.valid)
        else $error("accepted pixel did not reach the memory stage");

    a_s1_reaches_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_ctl.valid |=> s2_valid)
        else $error("memory stage item did not reach the window stage");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_count == CNT_W'(lpd5_pkg::FIFO_DEPTH)) |-> !push)
        else $error("result pushed into a full queue");

    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (CNT_W+2)'(lpd5_pkg::FIFO_DEPTH))
        else $error("pipeline occupancy exceeds queue depth");

endmodule
